FILE: rtl/core/hrlc_pkg.sv
`timescale 1ns / 1ps

package hrlc_pkg;

  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] SlashByte = 8'h2f;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] DigitOne  = 8'h31;

  // word numbers as counted from the start of the line
  localparam logic [2:0] WordNone  = 3'd0;
  localparam logic [2:0] WordGet   = 3'd1;
  localparam logic [2:0] WordUrl   = 3'd2;
  localparam logic [2:0] WordProto = 3'd3;
  localparam logic [2:0] WordMax   = 3'd4;

  localparam logic [3:0] GetLen    = 4'd3;
  localparam logic [3:0] PrefixLen = 4'd8;  // "HTTP/1." plus the minor digit
  localparam logic [3:0] PosMax    = 4'd15;
  localparam logic [8:0] UrlCntMax = 9'd256;
  localparam logic [7:0] UrlLimitRst = 8'd255;

  typedef enum logic [1:0] {
    VerdictRoot  = 2'd0,
    VerdictOther = 2'd1,
    VerdictBad   = 2'd2
  } verdict_e;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;  // G
      2'd1:    c = 8'h45;  // E
      2'd2:    c = 8'h54;  // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2f;  // /
      3'd5:    c = 8'h31;  // 1
      3'd6:    c = 8'h2e;  // .
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/hrlc_line_if.sv
`timescale 1ns / 1ps

interface hrlc_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_end;

  modport source (output valid, output line_byte, output line_end, input ready);
  modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

FILE: rtl/core/hrlc_result_if.sv
`timescale 1ns / 1ps

interface hrlc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [7:0] url_length;

  modport source (output valid, output verdict, output url_length, input ready);
  modport sink   (input valid, input verdict, input url_length, output ready);
endinterface

FILE: rtl/core/hrlc_cfg_if.sv
`timescale 1ns / 1ps

interface hrlc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_limit;

  modport source (output valid, output url_limit, input ready);
  modport sink   (input valid, input url_limit, output ready);
endinterface

FILE: rtl/core/http_request_line_checker_core.sv
`timescale 1ns / 1ps
// Latency: a result appears in the cycle after the last byte of a line is taken.
// Throughput: one byte per clock; the line state and the result register update
//   in the same cycle, so the next byte is taken in the cycle a waiting result is read.
// Stall: bytes stop only while a result sits unread and the sink holds ready low.
// Reset (rst_ni low, async): line state and result valid clear, url_limit -> 255.

module http_request_line_checker_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  hrlc_line_if.sink     line_i,
  hrlc_cfg_if.sink      cfg_i,
  hrlc_result_if.source result_o
);
  import hrlc_pkg::*;

  // Per-line state: the state registers act as the input stage, the
  // result register is the output stage.
  logic [2:0] word_idx_q, word_idx_d;
  logic       in_word_q, in_word_d;
  logic [3:0] pos_q, pos_d;
  logic [8:0] url_cnt_q, url_cnt_d;
  logic       url_slash_q, url_slash_d;
  logic       rej_q, rej_d;

  logic [7:0] url_limit_q;

  logic       res_valid_q;
  verdict_e   verdict_q, verdict_d;
  logic [7:0] url_len_q, url_len_d;

  logic line_acc;
  logic line_ready;

  // A closing word is bad if the method is not exactly three bytes or the
  // protocol word is shorter than the version prefix.
  function automatic logic close_bad(input logic [2:0] wi, input logic [3:0] mp);
    return ((wi == WordGet) && (mp != GetLen)) ||
           ((wi == WordProto) && (mp < PrefixLen));
  endfunction

  // Output slot frees up when empty or being drained this cycle.
  assign line_ready   = !res_valid_q || result_o.ready;
  assign line_i.ready = line_ready;
  assign line_acc     = line_i.valid && line_ready;

  assign cfg_i.ready  = 1'b1;

  always_comb begin
    logic [7:0] b;
    logic [2:0] wi;
    logic       inw;
    logic [3:0] mp;
    logic [8:0] uc;
    logic       sl;
    logic       rj;

    b  = line_i.line_byte;
    wi = word_idx_q;
    inw = in_word_q;
    mp = pos_q;
    uc = url_cnt_q;
    sl = url_slash_q;
    rj = rej_q;

    if (b == SpaceByte) begin
      if (inw) begin
        rj  = rj | close_bad(wi, mp);
        inw = 1'b0;
      end
    end else begin
      if (!inw) begin
        inw = 1'b1;
        mp  = '0;
        if (wi < WordMax) begin
          wi = wi + 3'd1;
        end
      end
      // check the byte against its position in the current word
      if (wi == WordGet) begin
        if ((mp >= GetLen) || (b != get_char(mp[1:0]))) begin
          rj = 1'b1;
        end
      end else if (wi == WordUrl) begin
        sl = (mp == '0) && (b == SlashByte);
        if (uc < UrlCntMax) begin
          uc = uc + 9'd1;
        end
      end else if (wi == WordProto) begin
        if (mp < (PrefixLen - 4'd1)) begin
          if (b != prefix_char(mp[2:0])) begin
            rj = 1'b1;
          end
        end else if (mp == (PrefixLen - 4'd1)) begin
          if ((b != DigitZero) && (b != DigitOne)) begin
            rj = 1'b1;
          end
        end
      end
      if (mp < PosMax) begin
        mp = mp + 4'd1;
      end
    end

    // line end: close any open word, then judge
    if (inw) begin
      verdict_d = VerdictOther;
      if (rj || close_bad(wi, mp) || (wi != WordProto)) begin
        verdict_d = VerdictBad;
      end else if ((uc == 9'd1) && sl && (url_limit_q != '0)) begin
        verdict_d = VerdictRoot;
      end
    end else begin
      verdict_d = VerdictOther;
      if (rj || (wi != WordProto)) begin
        verdict_d = VerdictBad;
      end else if ((uc == 9'd1) && sl && (url_limit_q != '0)) begin
        verdict_d = VerdictRoot;
      end
    end
    url_len_d = uc[8] ? 8'hff : uc[7:0];

    if (line_i.line_end) begin
      // clear for the next line
      word_idx_d  = WordNone;
      in_word_d   = 1'b0;
      pos_d       = '0;
      url_cnt_d   = '0;
      url_slash_d = 1'b0;
      rej_d       = 1'b0;
    end else begin
      word_idx_d  = wi;
      in_word_d   = inw;
      pos_d       = mp;
      url_cnt_d   = uc;
      url_slash_d = sl;
      rej_d       = rj;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_idx_q  <= WordNone;
      in_word_q   <= 1'b0;
      pos_q       <= '0;
      url_cnt_q   <= '0;
      url_slash_q <= 1'b0;
      rej_q       <= 1'b0;
    end else if (line_acc) begin
      word_idx_q  <= word_idx_d;
      in_word_q   <= in_word_d;
      pos_q       <= pos_d;
      url_cnt_q   <= url_cnt_d;
      url_slash_q <= url_slash_d;
      rej_q       <= rej_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_limit_q <= UrlLimitRst;
    end else if (cfg_i.valid) begin
      url_limit_q <= cfg_i.url_limit;
    end
  end

  // result register: loaded on the last byte, held until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (line_acc && line_i.line_end) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_acc && line_i.line_end) begin
      verdict_q <= verdict_d;
      url_len_q <= url_len_d;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.verdict    = verdict_q;
  assign result_o.url_length = url_len_q;

endmodule

FILE: rtl/core/hrlc_checker.sv
`timescale 1ns / 1ps

module hrlc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       line_valid_i,
  input logic       line_ready_i,
  input logic       line_end_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] verdict_i,
  input logic [7:0] url_length_i
);
  import hrlc_pkg::*;

  // last byte always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_valid_i && line_ready_i && line_end_i |=> res_valid_i)
    else $error("no result after last byte");

  // a middle byte never produces a result
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_valid_i && line_ready_i && !line_end_i && !(res_valid_i && !res_ready_i)
    |=> !res_valid_i)
    else $error("result without last byte");

  // a root verdict always means a one-byte URL
  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (verdict_i == VerdictRoot) |-> (url_length_i == 8'd1))
    else $error("root verdict with URL length other than one");

  // stalled result holds its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(verdict_i) && $stable(url_length_i))
    else $error("stalled result changed");

endmodule

bind http_request_line_checker_core hrlc_checker u_hrlc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .line_valid_i (line_i.valid),
  .line_ready_i (line_i.ready),
  .line_end_i   (line_i.line_end),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .verdict_i    (result_o.verdict),
  .url_length_i (result_o.url_length)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hrlc_pkg::*;

  // the receiver holds ready low this long once, so bytes back up behind a result
  localparam int HoldCycles    = 300;
  // cycles with no handshake on any channel before the run is called hung
  localparam int WatchdogLimit = 4000;
  // least count of random bytes sent under each url_limit setting; the last line is sent whole
  localparam int PhaseBytes    = 25;

  localparam logic [23:0] GetText   = "GET";
  localparam logic [55:0] ProtoText = "HTTP/1.";
  localparam logic [7:0]  NewLine   = 8'h0a;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] url_length;
  } line_result_t;

  // Line parser model plus the queue of verdicts it predicts.
  class line_scoreboard;
    logic [7:0]   url_limit;
    logic [2:0]   word_num;
    logic         in_word;
    logic [3:0]   word_pos;
    logic [8:0]   url_cnt;
    logic         url_slash;
    logic         bad;
    line_result_t expected_q[$];
    int           mismatches;
    int           results_checked;
    int           verdict_seen[3];

    function new();
      url_limit       = UrlLimitRst;
      mismatches      = 0;
      results_checked = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
      clear_line();
    endfunction

    function void clear_line();
      word_num  = WordNone;
      in_word   = 1'b0;
      word_pos  = '0;
      url_cnt   = '0;
      url_slash = 1'b0;
      bad       = 1'b0;
    endfunction

    function void set_limit(logic [7:0] value);
      url_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void close_word();
      if (word_num == WordGet && word_pos != GetLen) bad = 1'b1;
      if (word_num == WordProto && word_pos < PrefixLen) bad = 1'b1;
      in_word = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      int p;
      if (b == SpaceByte) begin
        if (in_word) close_word();
        return;
      end
      if (!in_word) begin
        in_word  = 1'b1;
        word_pos = '0;
        if (word_num < WordMax) word_num++;
      end
      p = int'(word_pos);
      case (word_num)
        WordGet: begin
          if (p >= int'(GetLen) || b != GetText[8*(2-p) +: 8]) bad = 1'b1;
        end
        WordUrl: begin
          url_slash = (p == 0 && b == SlashByte);
          if (url_cnt < UrlCntMax) url_cnt++;
        end
        WordProto: begin
          if (p < int'(PrefixLen) - 1) begin
            if (b != ProtoText[8*(6-p) +: 8]) bad = 1'b1;
          end else if (p == int'(PrefixLen) - 1) begin
            if (b != DigitZero && b != DigitOne) bad = 1'b1;
          end
        end
        default: ;
      endcase
      if (word_pos < PosMax) word_pos++;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      line_result_t r;
      take_byte(b);
      if (!last) return;
      if (in_word) close_word();
      if (bad || word_num != WordProto) r.verdict = VerdictBad;
      else if (url_cnt == 9'd1 && url_slash && url_cnt <= {1'b0, url_limit})
        r.verdict = VerdictRoot;
      else r.verdict = VerdictOther;
      r.url_length = (url_cnt > 9'd255) ? 8'd255 : url_cnt[7:0];
      expected_q.push_back(r);
      clear_line();
    endfunction

    function void check_result(logic [1:0] verdict, logic [7:0] url_length);
      line_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("verdict %0d length %0d with no line pending", verdict, url_length));
        return;
      end
      e = expected_q.pop_front();
      results_checked++;
      if (verdict !== e.verdict || url_length !== e.url_length)
        report($sformatf("line %0d: expected verdict %0d length %0d, got verdict %0d length %0d",
                         results_checked, e.verdict, e.url_length, verdict, url_length));
      else verdict_seen[int'(e.verdict)]++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hrlc_line_if   line_bus ();
  hrlc_cfg_if    cfg_bus ();
  hrlc_result_if result_bus ();

  http_request_line_checker_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .line_i   (line_bus),
    .cfg_i    (cfg_bus),
    .result_o (result_bus)
  );

  line_scoreboard sb;
  logic [7:0]     line_q[$];     // bytes of the line being built
  bit             hold_request;  // set by stimulus, cleared by the receiver
  int             bytes_sent;
  int             lines_sent;
  int             limits_written;
  int             idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled at the rising edge, before any flop moves.
  // Results are checked ahead of new bytes so a line end and the previous
  // line's verdict in the same cycle still pair up in order.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (result_bus.valid && result_bus.ready) begin
        sb.check_result(result_bus.verdict, result_bus.url_length);
        idle_cycles = 0;
      end
      if (line_bus.valid && line_bus.ready) begin
        sb.note_byte(line_bus.line_byte, line_bus.line_end);
        idle_cycles = 0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.set_limit(cfg_bus.url_limit);
        idle_cycles = 0;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // mostly no gap, a few short ones, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result receiver: runs of ready, random stalls, and the one long hold-off.
  initial begin
    int run_left;
    int stall_left;
    result_bus.ready = 1'b0;
    run_left   = 0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        result_bus.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (run_left > 0) begin
        result_bus.ready = 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        result_bus.ready = 1'b0;
        stall_left--;
      end else begin
        // long runs give stretches with no stall at all
        run_left   = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 6);
        stall_left = pick_gap();
        result_bus.ready = 1'b1;
        run_left--;
      end
    end
  end

  function automatic logic [7:0] word_byte(bit printable);
    logic [7:0] b;
    b = printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
    if (b == SpaceByte) b = 8'h21;
    return b;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) line_q.push_back(SpaceByte);
  endfunction

  function automatic void add_word(int n, bit printable);
    repeat (n) line_q.push_back(word_byte(printable));
  endfunction

  // Mostly well-formed lines with random URL and version tails; the rest
  // broken method or protocol, wrong word counts, or plain noise.
  function automatic void build_random_line();
    int          shape;
    int          r;
    int          n;
    logic [63:0] proto;
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 24);
      repeat (n)
        line_q.push_back(($urandom_range(0, 3) == 0) ? SpaceByte : 8'($urandom_range(0, 255)));
      return;
    end
    shape = $urandom_range(0, 99);  // <10 one word, <16 two, <24 four, else three
    if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 3));
    case ($urandom_range(0, 19))
      0: add_text("GE");
      1: add_text("GETS");
      2: add_text("get");
      3: begin
        add_text("GET");
        line_q[line_q.size() - 1 - $urandom_range(0, 2)] = word_byte(1'b1);
      end
      default: add_text("GET");
    endcase
    if (shape >= 10) begin
      add_spaces($urandom_range(1, 3));
      r = $urandom_range(0, 99);
      if (r < 30) begin
        line_q.push_back(SlashByte);
      end else if (r < 33) begin
        // up to and past the 255 saturation point
        line_q.push_back(SlashByte);
        add_word($urandom_range(200, 300), 1'b1);
      end else begin
        if (r < 70) line_q.push_back(SlashByte);
        add_word($urandom_range(1, 11), $urandom_range(0, 3) != 0);
      end
    end
    if (shape >= 16) begin
      add_spaces($urandom_range(1, 3));
      proto = $urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0";
      r = $urandom_range(0, 99);
      n = (r >= 88) ? $urandom_range(1, 7) : 8;
      for (int i = 0; i < n; i++) line_q.push_back(proto[8*(7-i) +: 8]);
      if (r >= 75 && r < 88)
        line_q[line_q.size() - 1 - $urandom_range(0, 7)] = word_byte(1'b1);
      if ($urandom_range(0, 9) < 3) add_word($urandom_range(1, 12), $urandom_range(0, 1));
    end
    if (shape >= 16 && shape < 24) begin
      add_spaces($urandom_range(1, 2));
      add_word($urandom_range(1, 5), 1'b1);
    end
    case ($urandom_range(0, 3))
      0, 1: line_q.push_back(NewLine);
      2:    add_spaces($urandom_range(1, 2));
      default: ;
    endcase
  endfunction

  // Sends the bytes in line_q, line_end on the last; valid stays high
  // across bytes unless a gap is drawn.
  task automatic send_line();
    bit steady;
    int gap;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < line_q.size(); i++) begin
      @(negedge clk_i);
      line_bus.valid     = 1'b1;
      line_bus.line_byte = line_q[i];
      line_bus.line_end  = (i == line_q.size() - 1);
      @(posedge clk_i);
      while (line_bus.ready !== 1'b1) @(posedge clk_i);
      bytes_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        line_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    lines_sent++;
    line_q.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_line();
  endtask

  // stop offering bytes and let every outstanding verdict come back
  task automatic wait_idle();
    @(negedge clk_i);
    line_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_url_limit(input logic [7:0] value);
    wait_idle();
    cfg_bus.url_limit = value;
    cfg_bus.valid     = 1'b1;
    @(posedge clk_i);
    while (cfg_bus.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    limits_written++;
  endtask

  initial begin
    int phase_limit[5];
    int phase_start;
    sb                 = new();
    rst_ni             = 1'b0;
    line_bus.valid     = 1'b0;
    line_bus.line_byte = '0;
    line_bus.line_end  = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.url_limit  = '0;
    hold_request       = 1'b0;
    bytes_sent         = 0;
    lines_sent         = 0;
    limits_written     = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    // one long hold-off on results while the directed lines keep coming
    hold_request = 1'b1;

    // Directed lines under the reset limit of 255.
    send_text("GET / HTTP/1.1\n");                // root
    send_text("GET /index.html HTTP/1.0\n");      // other URL
    send_text("   GET  /a   HTTP/1.1   ");        // extra spaces, ends on a space
    send_text("GE / HTTP/1.1\n");                 // method too short
    send_text("GETS / HTTP/1.1\n");               // method too long
    send_text("get / HTTP/1.1\n");                // method case
    send_text("GET / HTTP/1.");                   // protocol word too short
    send_text("GET / HTTP/1.2\n");                // bad minor digit
    send_text("GET /\n");                         // two words
    send_text("GET / HTTP/1.1 x\n");              // four words
    send_text("GET / HTTP/1.0 GET / HTTP/1.1\n"); // word count saturates
    send_text(" ");                               // no words at all
    send_text("\n");                              // newline alone is a word
    send_text("GET // HTTP/1.0");                 // slash twice is not root
    send_text("GET x HTTP/1.1xyzzy-and-more\n");  // long protocol word
    add_text("GET ");
    line_q.push_back(8'h00);
    line_q.push_back(8'hff);
    line_q.push_back(8'h80);
    add_text(" HTTP/1.1\n");
    send_line();
    add_text("GET /");
    add_word(259, 1'b1);
    add_text(" HTTP/1.0\n");
    send_line();                                  // URL length saturates

    // "/" is over a limit of 0 and counts as an ordinary URL
    write_url_limit(8'd0);
    send_text("GET / HTTP/1.1\n");
    send_text("GET /x HTTP/1.0\n");
    write_url_limit(8'd1);
    send_text("GET / HTTP/1.1\n");

    // Random lines under several limits, extremes included.
    phase_limit[0] = $urandom_range(2, 254);
    phase_limit[1] = 0;
    phase_limit[2] = 1;
    phase_limit[3] = 255;
    phase_limit[4] = $urandom_range(0, 255);
    for (int k = 0; k < 5; k++) begin
      write_url_limit(8'(phase_limit[k]));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_random_line();
        send_line();
      end
    end

    wait_idle();
    $display("%0d request lines (%0d bytes): %0d root, %0d other, %0d bad verdicts matched",
             lines_sent, bytes_sent, sb.verdict_seen[int'(VerdictRoot)],
             sb.verdict_seen[int'(VerdictOther)], sb.verdict_seen[int'(VerdictBad)]);
    $display("%0d url_limit writes, %0d mismatches, %0d-cycle result hold-off",
             limits_written, sb.mismatches, HoldCycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/hrlc_pkg.sv
rtl/core/hrlc_line_if.sv
rtl/core/hrlc_result_if.sv
rtl/core/hrlc_cfg_if.sv
rtl/core/http_request_line_checker_core.sv
rtl/core/hrlc_checker.sv
tb/tb.sv
